@@ rtl/ata_pkg.sv @@
// Shared types, widths and constants for the accelerometer tilt angle unit.
// Used by every module of the block; depends on nothing.
package ata_pkg;

    // Input samples and fixed-point formats
    localparam int SAMPLE_W   = 16;
    localparam int ANGLE_FRAC = 16;

    // CORDIC iteration count and the length of the arctangent table
    localparam int ANGLE_STEPS  = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_STEPS = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;

    // Magnitude path: squares, their sum, and the bit-per-stage square root
    localparam int PROD_W     = 2 * SAMPLE_W - 1;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int MAG_W      = SQ_W;
    localparam int ROOT_STEPS = MAG_W;
    localparam int REM_W      = MAG_W + 3;

    // CORDIC datapath widths
    localparam int IN_W   = SAMPLE_W + ANGLE_FRAC + 1;
    localparam int VEC_W  = IN_W + 2;
    localparam int Z_W    = 26;
    localparam int ATAN_W = 22;

    // Rounding to 1/128 degree and output formats
    localparam int OUT_SHIFT = 9;
    localparam int RND_HALF  = 256;
    localparam int RND_W     = Z_W + 1 - OUT_SHIFT;
    localparam int ANG_W     = 16;
    localparam int PITCH_W   = 15;
    localparam int ROLL_W    = 16;
    localparam int LIM_W     = 15;
    localparam int PITCH_LIM = 11520;
    localparam int ROLL_LIM  = 23040;

    localparam logic [Z_W-1:0] DEG90 = Z_W'(90 * 65536);

    // atan(2^-i) in degrees with 16 fraction bits, rounded
    localparam logic [ATAN_W-1:0] ATAN_DEG [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } sample_t;

    // One beat from the magnitude pipeline to the angle units
    typedef struct packed {
        logic             valid;
        sample_t          sample;
        logic [MAG_W-1:0] mag;
    } mag_beat_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  roll;
    } angles_t;

endpackage

@@ rtl/ata_mag.sv @@
// Magnitude pipeline: squares y and z, sums them and takes sqrt(sum) with
// 16 fraction bits, one root bit per stage. Depends on ata_pkg.
module ata_mag (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              run,
    input  logic                              in_valid,
    input  ata_pkg::sample_t                  sample,
    output ata_pkg::mag_beat_t                beat
);

    localparam int NS = ata_pkg::ROOT_STEPS;

    // Product stage
    logic                            vld_p_reg;
    ata_pkg::sample_t                smp_p_reg;
    logic [ata_pkg::PROD_W-1:0]      prod_y_reg, prod_z_reg;
    logic [ata_pkg::PROD_W-1:0]      prod_y_next, prod_z_next;
    logic signed [2*ata_pkg::SAMPLE_W-1:0] py, pz;

    // Sum stage is index 0, root step j lands in index j+1
    logic                            vld_reg  [0:NS];
    ata_pkg::sample_t                smp_reg  [0:NS];
    logic [ata_pkg::SQ_W-1:0]        sq_reg   [0:NS];
    logic [ata_pkg::REM_W-1:0]       rem_reg  [1:NS];
    logic [ata_pkg::MAG_W-1:0]       root_reg [1:NS];
    logic [ata_pkg::SQ_W-1:0]        sq_next;

    // Square the y and z samples
    always_comb
    begin
        py          = sample.y * sample.y;
        pz          = sample.z * sample.z;
        prod_y_next = py[ata_pkg::PROD_W-1:0];
        prod_z_next = pz[ata_pkg::PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_p_reg <= 1'b0;
        end
        else if (run)
        begin
            vld_p_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            smp_p_reg  <= sample;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
        end
    end

    // Add the squares
    assign sq_next = ata_pkg::SQ_W'(prod_y_reg) + ata_pkg::SQ_W'(prod_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (run)
        begin
            vld_reg[0] <= vld_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            smp_reg[0] <= smp_p_reg;
            sq_reg[0]  <= sq_next;
        end
    end

    // Restoring square root of sum * 2^32, one result bit per stage
    for (genvar j = 0; j < NS; j++)
    begin : g_root
        logic [1:0]                 pair;
        logic [ata_pkg::REM_W-1:0]  rem_cur, rem_sh, trial, rem_next;
        logic [ata_pkg::MAG_W-1:0]  root_cur, root_next;

        // The radicand is the sum followed by zero bits
        if (j < ata_pkg::SQ_W / 2)
        begin : g_pair
            assign pair = sq_reg[j][ata_pkg::SQ_W-1-2*j -: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        if (j == 0)
        begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
        end
        else
        begin : g_next
            assign rem_cur  = rem_reg[j];
            assign root_cur = root_reg[j];
        end

        always_comb
        begin
            rem_sh = {rem_cur[ata_pkg::REM_W-3:0], pair};
            trial  = {1'b0, root_cur, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_cur[ata_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_cur[ata_pkg::MAG_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (run)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (run)
            begin
                smp_reg[j+1]  <= smp_reg[j];
                sq_reg[j+1]   <= sq_reg[j];
                rem_reg[j+1]  <= rem_next;
                root_reg[j+1] <= root_next;
            end
        end
    end

    assign beat.valid  = vld_reg[NS];
    assign beat.sample = smp_reg[NS];
    assign beat.mag    = root_reg[NS];

endmodule

@@ rtl/ata_cordic.sv @@
// Pipelined vectoring CORDIC: atan2(yv, xv) in degrees, rounded to 1/128
// degree and clamped to +-lim. One iteration per stage. Depends on ata_pkg.
module ata_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              run,
    input  logic                              in_valid,
    input  logic signed [ata_pkg::IN_W-1:0]   yv,
    input  logic signed [ata_pkg::IN_W-1:0]   xv,
    input  logic [ata_pkg::LIM_W-1:0]         lim,
    output logic                              ang_valid,
    output logic signed [ata_pkg::ANG_W-1:0]  angle
);

    localparam int NS = ata_pkg::CORDIC_STEPS;
    localparam int EXT = ata_pkg::VEC_W - ata_pkg::IN_W;

    logic                               vld_reg [0:NS];
    logic                               fix_reg [0:NS];
    logic signed [ata_pkg::VEC_W-1:0]   x_reg   [0:NS];
    logic signed [ata_pkg::VEC_W-1:0]   y_reg   [0:NS];
    logic signed [ata_pkg::Z_W-1:0]     z_reg   [0:NS];

    logic signed [ata_pkg::VEC_W-1:0]   xe, ye, x0_next, y0_next;
    logic signed [ata_pkg::Z_W-1:0]     z0_next;
    logic                               fix0_next;

    // Resolve a zero abscissa and turn the left half plane by 90 degrees
    always_comb
    begin
        xe        = {{EXT{xv[ata_pkg::IN_W-1]}}, xv};
        ye        = {{EXT{yv[ata_pkg::IN_W-1]}}, yv};
        x0_next   = xe;
        y0_next   = ye;
        z0_next   = '0;
        fix0_next = 1'b0;
        if (xe == '0)
        begin
            fix0_next = 1'b1;
            if (ye[ata_pkg::VEC_W-1])
            begin
                z0_next = -$signed(ata_pkg::DEG90);
            end
            else if (ye != '0)
            begin
                z0_next = $signed(ata_pkg::DEG90);
            end
        end
        else if (xe[ata_pkg::VEC_W-1])
        begin
            if (!ye[ata_pkg::VEC_W-1])
            begin
                x0_next = ye;
                y0_next = -xe;
                z0_next = $signed(ata_pkg::DEG90);
            end
            else
            begin
                x0_next = -ye;
                y0_next = xe;
                z0_next = -$signed(ata_pkg::DEG90);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (run)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            fix_reg[0] <= fix0_next;
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            z_reg[0]   <= z0_next;
        end
    end

    // Micro-rotations: drive y toward zero, accumulate the angle
    for (genvar i = 0; i < NS; i++)
    begin : g_iter
        logic signed [ata_pkg::VEC_W-1:0] xs, ys, x_next, y_next;
        logic signed [ata_pkg::Z_W-1:0]   step, z_next;

        always_comb
        begin
            xs   = x_reg[i] >>> i;
            ys   = y_reg[i] >>> i;
            step = ata_pkg::Z_W'(ata_pkg::ATAN_DEG[i]);
            if (!y_reg[i][ata_pkg::VEC_W-1] && (y_reg[i] != '0))
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + step;
            end
            else
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - step;
            end
            // hold the angle already fixed by a zero abscissa
            if (fix_reg[i])
            begin
                z_next = z_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (run)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (run)
            begin
                fix_reg[i+1] <= fix_reg[i];
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
            end
        end
    end

    // Round half up to 1/128 degree, then clamp
    logic [ata_pkg::Z_W:0]              z_rnd;
    logic signed [ata_pkg::RND_W-1:0]   r, lim_s, clip;
    logic                               ang_valid_reg;
    logic signed [ata_pkg::ANG_W-1:0]   ang_reg, ang_next;

    always_comb
    begin
        z_rnd = {z_reg[NS][ata_pkg::Z_W-1], z_reg[NS]}
              + (ata_pkg::Z_W+1)'(ata_pkg::RND_HALF);
        r     = $signed(z_rnd[ata_pkg::Z_W:ata_pkg::OUT_SHIFT]);
        lim_s = $signed({{(ata_pkg::RND_W-ata_pkg::LIM_W){1'b0}}, lim});
        if (r > lim_s)
        begin
            clip = lim_s;
        end
        else if (r < -lim_s)
        begin
            clip = -lim_s;
        end
        else
        begin
            clip = r;
        end
        ang_next = clip[ata_pkg::ANG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_valid_reg <= 1'b0;
        end
        else if (run)
        begin
            ang_valid_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            ang_reg <= ang_next;
        end
    end

    assign ang_valid = ang_valid_reg;
    assign angle     = ang_reg;

endmodule

@@ rtl/ata_outbuf.sv @@
// Output register with a one-beat skid stage; freezes the pipeline only
// while the skid stage is occupied. Depends on ata_pkg.
module ata_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  ata_pkg::angles_t  res,
    input  logic              out_ready,
    output logic              out_valid,
    output ata_pkg::angles_t  out_res,
    output logic              run
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    ata_pkg::angles_t out_reg, out_next;
    ata_pkg::angles_t skid_reg, skid_next;
    logic             take, arrive;

    // Steer the arriving beat into the output or the skid stage
    always_comb
    begin
        take            = out_valid_reg && out_ready;
        arrive          = !skid_valid_reg && res_valid;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign run       = !skid_valid_reg;

endmodule

@@ rtl/accel_tilt_angles_unit.sv @@
// Accelerometer tilt angles: pitch = atan2(-x, |(y,z)|), roll = atan2(y, z).
// Pipeline from accepted beat to out_valid: 2 for squares and sum,
//   32 for the bit-per-stage square root, 1 pre-rotation, ANGLE_STEPS CORDIC
//   stages, 1 rounding stage, 1 output register.
// Throughput: one beat per cycle; in_ready drops only while the skid stage is full.
// Reset: rst_n clears all valid bits at once; data registers are not reset.
module accel_tilt_angles_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ata_pkg::SAMPLE_W-1:0]  accel_x,
    input  logic signed [ata_pkg::SAMPLE_W-1:0]  accel_y,
    input  logic signed [ata_pkg::SAMPLE_W-1:0]  accel_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ata_pkg::PITCH_W-1:0]   pitch_angle,
    output logic signed [ata_pkg::ROLL_W-1:0]    roll_angle
);

    logic                               run;
    ata_pkg::sample_t                   sample;
    ata_pkg::mag_beat_t                 mag_beat;
    logic signed [ata_pkg::SAMPLE_W:0]  neg_x;
    logic signed [ata_pkg::IN_W-1:0]    pitch_y, pitch_x, roll_y, roll_x;
    logic                               p_valid, r_valid;
    logic signed [ata_pkg::ANG_W-1:0]   p_angle, r_angle;
    ata_pkg::angles_t                   res, out_res;

    assign sample.x = accel_x;
    assign sample.y = accel_y;
    assign sample.z = accel_z;

    ata_mag u_mag (
        .clk      (clk),
        .rst_n    (rst_n),
        .run      (run),
        .in_valid (in_valid),
        .sample   (sample),
        .beat     (mag_beat)
    );

    // Build the angle unit operands, all scaled by 2^16
    always_comb
    begin
        neg_x   = -{mag_beat.sample.x[ata_pkg::SAMPLE_W-1], mag_beat.sample.x};
        pitch_y = {neg_x, {ata_pkg::ANGLE_FRAC{1'b0}}};
        pitch_x = {1'b0, mag_beat.mag};
        roll_y  = {mag_beat.sample.y[ata_pkg::SAMPLE_W-1], mag_beat.sample.y,
                   {ata_pkg::ANGLE_FRAC{1'b0}}};
        roll_x  = {mag_beat.sample.z[ata_pkg::SAMPLE_W-1], mag_beat.sample.z,
                   {ata_pkg::ANGLE_FRAC{1'b0}}};
    end

    ata_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .in_valid  (mag_beat.valid),
        .yv        (pitch_y),
        .xv        (pitch_x),
        .lim       (ata_pkg::LIM_W'(ata_pkg::PITCH_LIM)),
        .ang_valid (p_valid),
        .angle     (p_angle)
    );

    ata_cordic u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .in_valid  (mag_beat.valid),
        .yv        (roll_y),
        .xv        (roll_x),
        .lim       (ata_pkg::LIM_W'(ata_pkg::ROLL_LIM)),
        .ang_valid (r_valid),
        .angle     (r_angle)
    );

    assign res.pitch = p_angle[ata_pkg::PITCH_W-1:0];
    assign res.roll  = r_angle[ata_pkg::ROLL_W-1:0];

    ata_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (p_valid && r_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .run       (run)
    );

    assign in_ready    = run;
    assign pitch_angle = out_res.pitch;
    assign roll_angle  = out_res.roll;

endmodule

@@ rtl/ata_checker.sv @@
// Port-level checks for accel_tilt_angles_unit, attached by the bind below.
// Depends on ata_pkg for the angle limits.
module ata_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [ata_pkg::PITCH_W-1:0]   pitch_angle,
    input logic signed [ata_pkg::ROLL_W-1:0]    roll_angle
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pitch_angle) && $stable(roll_angle))
        else $error("result beat changed while stalled");

    // Pitch stays within +-90 degrees
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(pitch_angle) <= ata_pkg::PITCH_LIM)
                   && ($signed(pitch_angle) >= -ata_pkg::PITCH_LIM))
        else $error("pitch out of range");

    // Roll stays within +-180 degrees
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(roll_angle) <= ata_pkg::ROLL_LIM)
                   && ($signed(roll_angle) >= -ata_pkg::ROLL_LIM))
        else $error("roll out of range");

    // Drop ready only after a stalled result
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input ready fell without an output stall");

    // Backpressure only while a result is waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input ready low with no pending result");

endmodule

bind accel_tilt_angles_unit ata_checker u_ata_checker (.*);

@@ bench/testbench.sv @@
// Self-checking bench for the accelerometer tilt angle unit (accel_tilt_angles_unit).
// Depends on rtl/ata_pkg.sv for port widths; predicts pitch and roll with its own CORDIC model.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        ata_pkg::sample_t                   sample;
        logic signed [ata_pkg::PITCH_W-1:0] pitch;
        logic signed [ata_pkg::ROLL_W-1:0]  roll;
    } tilt_result_t;

    // Tilt angle predictor and the queue of angles still owed by the block
    class tilt_scoreboard;
        tilt_result_t pending_angles[$];
        int           mismatches = 0;
        longint       atan_q16 [24] = '{
            2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0
        };

        task report_mismatch(input string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Exact integer square root of a 64-bit value, bit by bit
        function longint root64(input bit [63:0] n);
            bit [63:0] rem;
            bit [63:0] res;
            bit [63:0] one;
            rem = n;
            res = 0;
            one = 64'h4000_0000_0000_0000;
            while (one > rem)
                one = one >> 2;
            while (one != 0)
            begin
                if (rem >= res + one)
                begin
                    rem = rem - (res + one);
                    res = (res >> 1) + one;
                end
                else
                    res = res >> 1;
                one = one >> 2;
            end
            return longint'(res);
        endfunction

        // Vectoring CORDIC: atan2(yv, xv) in degrees with 16 fraction bits
        function longint angle_of(input longint yv, input longint xv);
            longint quarter;
            longint vx;
            longint vy;
            longint acc;
            longint hold;
            longint sx;
            longint sy;
            quarter = 90 * 65536;
            vx = xv;
            vy = yv;
            acc = 0;
            if (xv == 0)
                return (yv > 0) ? quarter : ((yv < 0) ? -quarter : 0);
            // turn a left-half-plane vector into the right half, zero ordinate counts positive
            if (xv < 0)
            begin
                hold = vx;
                if (yv >= 0)
                begin
                    vx = vy;
                    vy = -hold;
                    acc = quarter;
                end
                else
                begin
                    vx = -vy;
                    vy = hold;
                    acc = -quarter;
                end
            end
            for (int i = 0; i < ata_pkg::ANGLE_STEPS && i < 24; i++)
            begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vy > 0)
                begin
                    vx = vx + sy;
                    vy = vy - sx;
                    acc = acc + atan_q16[i];
                end
                else
                begin
                    vx = vx - sy;
                    vy = vy + sx;
                    acc = acc - atan_q16[i];
                end
            end
            return acc;
        endfunction

        // Round to 1/128 degree, halves up, and clamp to +-lim
        function longint to_lsb(input longint acc, input longint lim);
            longint r;
            r = (acc + 256) >>> 9;
            if (r > lim)
                r = lim;
            if (r < -lim)
                r = -lim;
            return r;
        endfunction

        function void note_sample(input ata_pkg::sample_t s);
            tilt_result_t e;
            longint ax;
            longint ay;
            longint az;
            longint mag;
            longint pitch_lsb;
            longint roll_lsb;
            ax = s.x;
            ay = s.y;
            az = s.z;
            mag = root64(64'(ay * ay + az * az) << 32);
            pitch_lsb = to_lsb(angle_of(-ax * 65536, mag), ata_pkg::PITCH_LIM);
            roll_lsb = to_lsb(angle_of(ay * 65536, az * 65536), ata_pkg::ROLL_LIM);
            e.sample = s;
            e.pitch = pitch_lsb[ata_pkg::PITCH_W-1:0];
            e.roll = roll_lsb[ata_pkg::ROLL_W-1:0];
            pending_angles.push_back(e);
        endfunction

        task check_angles(input logic signed [ata_pkg::PITCH_W-1:0] pitch,
                          input logic signed [ata_pkg::ROLL_W-1:0] roll);
            tilt_result_t e;
            if (pending_angles.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat pitch=%0d roll=%0d", pitch, roll));
                return;
            end
            e = pending_angles.pop_front();
            if (pitch !== e.pitch)
                report_mismatch($sformatf("pitch for (%0d,%0d,%0d): got %0d, want %0d",
                    e.sample.x, e.sample.y, e.sample.z, pitch, e.pitch));
            if (roll !== e.roll)
                report_mismatch($sformatf("roll for (%0d,%0d,%0d): got %0d, want %0d",
                    e.sample.x, e.sample.y, e.sample.z, roll, e.roll));
        endtask

        task check_drained();
            if (pending_angles.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", pending_angles.size()));
        endtask
    endclass

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1100;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [ata_pkg::SAMPLE_W-1:0] accel_x = '0;
    logic signed [ata_pkg::SAMPLE_W-1:0] accel_y = '0;
    logic signed [ata_pkg::SAMPLE_W-1:0] accel_z = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [ata_pkg::PITCH_W-1:0]  pitch_angle;
    logic signed [ata_pkg::ROLL_W-1:0]   roll_angle;

    tilt_scoreboard angle_board = new();
    bit             gaps_on = 1'b1;
    int             quiet_cycles = 0;

    accel_tilt_angles_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pitch_angle(pitch_angle),
        .roll_angle (roll_angle)
    );

    always #2 clk = ~clk;

    // Drain result beats, stalling at random while gaps are enabled
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            angle_board.check_angles(pitch_angle, roll_angle);
        out_ready <= !(gaps_on && $urandom_range(99) < 32);
    end

    // End the run when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one sample, with an optional random gap first; hold until accepted
    task automatic drive_sample(input logic signed [ata_pkg::SAMPLE_W-1:0] x,
                                input logic signed [ata_pkg::SAMPLE_W-1:0] y,
                                input logic signed [ata_pkg::SAMPLE_W-1:0] z);
        ata_pkg::sample_t s;
        if (gaps_on && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 32);
        end
        in_valid <= 1'b1;
        accel_x <= x;
        accel_y <= y;
        accel_z <= z;
        do
            @(posedge clk);
        while (!in_ready);
        s.x = accel_x;
        s.y = accel_y;
        s.z = accel_z;
        angle_board.note_sample(s);
    endtask

    function automatic logic signed [ata_pkg::SAMPLE_W-1:0] pick_corner();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return -16'sd1;
            4: return 16'sd1;
            default: return ata_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic run_directed();
        // all-zero sample, zero (y,z) with both signs of x
        drive_sample(16'sd0, 16'sd0, 16'sd0);
        drive_sample(16'sh7fff, 16'sd0, 16'sd0);
        drive_sample(16'sh8000, 16'sd0, 16'sd0);
        drive_sample(-16'sd1, 16'sd0, 16'sd0);
        // zero abscissa for roll: y alone
        drive_sample(16'sd0, 16'sh7fff, 16'sd0);
        drive_sample(16'sd0, 16'sh8000, 16'sd0);
        drive_sample(16'sd0, 16'sd1, 16'sd0);
        drive_sample(16'sd0, -16'sd1, 16'sd0);
        // zero ordinate for roll: z alone, both signs; a negative abscissa gives +180
        drive_sample(16'sd0, 16'sd0, 16'sh8000);
        drive_sample(16'sd0, 16'sd0, -16'sd1);
        drive_sample(16'sd0, 16'sd0, 16'sd1);
        drive_sample(16'sd0, 16'sd0, 16'sh7fff);
        // negative abscissa in both lower and upper quadrants
        drive_sample(16'sd100, -16'sd1, -16'sd2);
        drive_sample(-16'sd100, 16'sd1, -16'sd2);
        // field extremes and largest magnitude
        drive_sample(16'sh8000, 16'sh8000, 16'sh8000);
        drive_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        drive_sample(16'sh7fff, 16'sh8000, 16'sh8000);
        drive_sample(16'sh8000, 16'sh7fff, 16'sh8000);
        drive_sample(16'sd1, 16'sd1, 16'sd1);
        drive_sample(-16'sd1, -16'sd1, -16'sd1);
        drive_sample(16'sd12345, 16'sh8000, 16'sd0);
        drive_sample(16'sd16384, 16'sd0, 16'sd16384);
        drive_sample(16'sd0, 16'sd16384, -16'sd16384);
    endtask

    initial
    begin
        logic signed [ata_pkg::SAMPLE_W-1:0] x;
        logic signed [ata_pkg::SAMPLE_W-1:0] y;
        logic signed [ata_pkg::SAMPLE_W-1:0] z;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // gap-free stretch in the middle of the run
            gaps_on = !(n >= 300 && n < 600);
            // let the pipeline empty once before resuming
            if (n == 700)
            begin
                in_valid <= 1'b0;
                while (angle_board.pending_angles.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                begin
                    x = ata_pkg::SAMPLE_W'($urandom);
                    y = ata_pkg::SAMPLE_W'($urandom);
                    z = ata_pkg::SAMPLE_W'($urandom);
                end
                5, 6:
                begin
                    x = ata_pkg::SAMPLE_W'($urandom_range(8)) - 16'sd4;
                    y = ata_pkg::SAMPLE_W'($urandom_range(8)) - 16'sd4;
                    z = ata_pkg::SAMPLE_W'($urandom_range(8)) - 16'sd4;
                end
                7:
                begin
                    x = ata_pkg::SAMPLE_W'($urandom);
                    y = $urandom_range(1) ? ata_pkg::SAMPLE_W'($urandom) : 16'sd0;
                    z = (y != 0) ? 16'sd0 : ata_pkg::SAMPLE_W'($urandom);
                end
                default:
                begin
                    x = pick_corner();
                    y = pick_corner();
                    z = pick_corner();
                end
            endcase
            drive_sample(x, y, z);
        end
        in_valid <= 1'b0;

        while (angle_board.pending_angles.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        angle_board.check_drained();
        if (angle_board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
